### hw/rtl/sfwp_pkg.sv
package sfwp_pkg;

  localparam int unsigned WORD_BYTES   = 4;
  localparam int unsigned LENGTH_LIMIT = 50;
  localparam int unsigned MAX_RESULTS  = 12;
  localparam int unsigned STORE_DEPTH  = 64;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned ADDR_W  = $clog2(STORE_DEPTH);
  localparam int unsigned LEN_W   = ADDR_W;
  localparam int unsigned SEL_W   = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
  localparam int unsigned CAP_W   = 8;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hAA;

  localparam int unsigned OUT_BITS  = BYTE_W + WORD_W + INDEX_W;
  localparam int unsigned OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

endpackage

### hw/rtl/sync_frame_word_parser.sv
// Sync-header frame parser: bytes 0xAA, 0xAA, channel, length, payload,
// then an 8-bit additive checksum over all earlier bytes of the frame.
// Input channel in_*: one received byte per item. Output channel out_*:
// one payload word per item, big-endian, with channel and index on each
// word and tlast on the final word of the frame. cfg_we/cfg_wdata write
// word_capacity; a frame is delivered only if it holds at least one whole
// word and fewer words than word_capacity.
// Throughput: one byte per cycle while parsing. After a good checksum
// byte of a frame that is delivered, in_tready drops while the payload
// is read back from the byte store, one byte per cycle through its single
// read port: each word passes through its reads, the read latency and the
// hand-off, and the input stays held until the last word is handed off.
// The output register lets the last word wait while parsing resumes; a
// stalled receiver holds word assembly at the hand-off step.
// Reset: parser hunts for the first sync byte, output empty,
// word_capacity = 255. The byte store is not cleared; only bytes written
// in the current frame are read.
module sync_frame_word_parser
  import sfwp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] rx_byte
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_TDATA-1:0] out_tdata,  // [7:0] channel, [39:8] word, [43:40] word_index
  output logic                 out_tlast,
  input  logic                 cfg_we,
  input  logic [CAP_W-1:0]     cfg_wdata
);

  typedef enum logic [2:0] {
    PH_HUNT0, PH_HUNT1, PH_CHAN, PH_LEN, PH_PAYLOAD, PH_CSUM
  } phase_t;

  typedef enum logic [1:0] {
    CT_RUN, CT_FETCH, CT_LAST, CT_EMIT
  } ctl_t;

  phase_t              phase_r, phase_nxt;
  ctl_t                ctl_r, ctl_nxt;
  logic [LEN_W-1:0]    remain_r, remain_nxt;
  logic [LEN_W-1:0]    bcount_r, bcount_nxt;
  logic [LEN_W-1:0]    flen_r, flen_nxt;
  logic [BYTE_W-1:0]   fchan_r, fchan_nxt;
  logic [BYTE_W-1:0]   sum_r, sum_nxt;
  logic [CAP_W-1:0]    cap_r;
  logic [INDEX_W-1:0]  wsel_r, wsel_nxt;
  logic [INDEX_W-1:0]  nwords_r, nwords_nxt;
  logic [SEL_W-1:0]    bsel_r, bsel_nxt;
  logic                rd_pend_r;
  logic [WORD_W-1:0]   acc_r;
  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_chan_r, out_chan_nxt;
  logic [WORD_W-1:0]   out_word_r, out_word_nxt;
  logic [INDEX_W-1:0]  out_idx_r, out_idx_nxt;
  logic                out_last_r, out_last_nxt;

  logic                in_acc;
  logic [BYTE_W-1:0]   b;
  logic [BYTE_W-1:0]   sum_add;
  logic [LEN_W-1:0]    wcount;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [BYTE_W-1:0]   ram_rdata;

  assign in_tready = (ctl_r == CT_RUN);
  assign in_acc    = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign sum_add   = sum_r + b;
  assign wcount    = flen_r / LEN_W'(WORD_BYTES);
  assign ram_we    = in_acc && (phase_r == PH_PAYLOAD) && (remain_r != '0);
  assign ram_raddr = ADDR_W'(ADDR_W'(wsel_r) * ADDR_W'(WORD_BYTES) + ADDR_W'(bsel_r));

  sfwp_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(bcount_r),
    .wdata(b),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    phase_nxt     = phase_r;
    ctl_nxt       = ctl_r;
    remain_nxt    = remain_r;
    bcount_nxt    = bcount_r;
    flen_nxt      = flen_r;
    fchan_nxt     = fchan_r;
    sum_nxt       = sum_r;
    wsel_nxt      = wsel_r;
    nwords_nxt    = nwords_r;
    bsel_nxt      = bsel_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_chan_nxt  = out_chan_r;
    out_word_nxt  = out_word_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;

    if (in_acc) begin
      case (phase_r)
        PH_HUNT0: begin
          if (b == SYNC_BYTE) begin
            phase_nxt = PH_HUNT1;
            sum_nxt   = b;
          end
        end
        PH_HUNT1: begin
          if (b == SYNC_BYTE) begin
            phase_nxt = PH_CHAN;
            sum_nxt   = sum_add;
          end else begin
            phase_nxt = PH_HUNT0;
          end
        end
        PH_CHAN: begin
          phase_nxt = PH_LEN;
          fchan_nxt = b;
          sum_nxt   = sum_add;
        end
        PH_LEN: begin
          if (b < BYTE_W'(LENGTH_LIMIT)) begin
            phase_nxt  = PH_PAYLOAD;
            flen_nxt   = b[LEN_W-1:0];
            remain_nxt = b[LEN_W-1:0];
            bcount_nxt = '0;
            sum_nxt    = sum_add;
          end else begin
            phase_nxt = PH_HUNT0;
          end
        end
        PH_PAYLOAD: begin
          if (remain_r != '0) begin
            bcount_nxt = bcount_r + LEN_W'(1);
            remain_nxt = remain_r - LEN_W'(1);
            sum_nxt    = sum_add;
            if (remain_r == LEN_W'(1)) begin
              phase_nxt = PH_CSUM;
            end
          end else begin
            phase_nxt = PH_HUNT0;
          end
        end
        PH_CSUM: begin
          phase_nxt = PH_HUNT0;
          if ((sum_r == b) && (wcount != '0) &&
              (CAP_W'(wcount) < cap_r)) begin
            ctl_nxt    = CT_FETCH;
            wsel_nxt   = '0;
            bsel_nxt   = '0;
            nwords_nxt = (wcount > LEN_W'(MAX_RESULTS)) ? INDEX_W'(MAX_RESULTS)
                                                          : INDEX_W'(wcount);
          end
        end
        default: begin
          phase_nxt = PH_HUNT0;
        end
      endcase
    end

    case (ctl_r)
      CT_RUN: begin
      end
      CT_FETCH: begin
        if (bsel_r == SEL_W'(WORD_BYTES - 1)) begin
          bsel_nxt = '0;
          ctl_nxt  = CT_LAST;
        end else begin
          bsel_nxt = bsel_r + SEL_W'(1);
        end
      end
      CT_LAST: begin
        ctl_nxt = CT_EMIT;
      end
      CT_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_chan_nxt  = fchan_r;
          out_word_nxt  = acc_r;
          out_idx_nxt   = wsel_r;
          out_last_nxt  = (wsel_r == nwords_r - INDEX_W'(1));
          if (wsel_r == nwords_r - INDEX_W'(1)) begin
            ctl_nxt = CT_RUN;
          end else begin
            wsel_nxt = wsel_r + INDEX_W'(1);
            ctl_nxt  = CT_FETCH;
          end
        end
      end
      default: begin
        ctl_nxt = CT_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT0;
      ctl_r       <= CT_RUN;
      remain_r    <= '0;
      bcount_r    <= '0;
      flen_r      <= '0;
      fchan_r     <= '0;
      sum_r       <= '0;
      cap_r       <= '1;
      wsel_r      <= '0;
      nwords_r    <= '0;
      bsel_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      ctl_r       <= ctl_nxt;
      remain_r    <= remain_nxt;
      bcount_r    <= bcount_nxt;
      flen_r      <= flen_nxt;
      fchan_r     <= fchan_nxt;
      sum_r       <= sum_nxt;
      wsel_r      <= wsel_nxt;
      nwords_r    <= nwords_nxt;
      bsel_r      <= bsel_nxt;
      rd_pend_r   <= (ctl_r == CT_FETCH);
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      acc_r <= WORD_W'({acc_r, ram_rdata});
    end
    out_chan_r <= out_chan_nxt;
    out_word_r <= out_word_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_TDATA'({out_idx_r, out_word_r, out_chan_r});

endmodule

### hw/rtl/sfwp_ram.sv
module sfwp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### tb/sfwp_word_checker.sv
module sfwp_word_checker
  import sfwp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [OUT_TDATA-1:0] out_tdata,
  input  logic                 out_tlast,
  input  logic                 cfg_we,
  input  logic [CAP_W-1:0]     cfg_wdata,
  output int                   mismatch_cnt,
  output int                   words_pending
);

  typedef enum logic [2:0] {
    HUNT_A, HUNT_B, GET_CHAN, GET_LEN, GET_DATA, GET_SUM
  } parse_phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  chan;
    logic [WORD_W-1:0]  word;
    logic [INDEX_W-1:0] idx;
    logic               last;
  } frame_word_t;

  frame_word_t       expected_words[$];
  parse_phase_t      phase;
  logic [LEN_W-1:0]  remain;
  logic [LEN_W-1:0]  wr_ptr;
  logic [LEN_W-1:0]  frame_len;
  logic [BYTE_W-1:0] frame_chan;
  logic [BYTE_W-1:0] csum;
  logic [CAP_W-1:0]  capacity;
  logic [BYTE_W-1:0] rx_store[STORE_DEPTH];

  task automatic emit_frame_words();
    int          nwords;
    int          n;
    logic [31:0] w;
    frame_word_t e;
    nwords = int'(frame_len) / WORD_BYTES;
    if (nwords != 0 && nwords < int'(capacity)) begin
      n = (nwords > MAX_RESULTS) ? MAX_RESULTS : nwords;
      for (int i = 0; i < n; i++) begin
        w = '0;
        for (int j = 0; j < WORD_BYTES; j++)
          w = (w << 8) | 32'(rx_store[(i * WORD_BYTES + j) % STORE_DEPTH]);
        e.chan = frame_chan;
        e.word = w;
        e.idx  = INDEX_W'(i);
        e.last = (i + 1 == n);
        expected_words.push_back(e);
      end
    end
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    if (phase == HUNT_A && b == SYNC_BYTE) begin
      phase = HUNT_B;
      csum  = b;
    end else if (phase == HUNT_B && b == SYNC_BYTE) begin
      phase = GET_CHAN;
      csum  = csum + b;
    end else if (phase == GET_CHAN) begin
      phase      = GET_LEN;
      frame_chan = b;
      csum       = csum + b;
    end else if (phase == GET_LEN && b < LENGTH_LIMIT) begin
      phase     = GET_DATA;
      frame_len = b[LEN_W-1:0];
      remain    = b[LEN_W-1:0];
      wr_ptr    = '0;
      csum      = csum + b;
    end else if (phase == GET_DATA && remain != 0) begin
      rx_store[wr_ptr] = b;
      wr_ptr = wr_ptr + 1'b1;
      remain = remain - 1'b1;
      csum   = csum + b;
      if (remain == 0) phase = GET_SUM;
    end else if (phase == GET_SUM) begin
      phase = HUNT_A;
      if (csum == b) emit_frame_words();
    end else begin
      phase = HUNT_A;
    end
  endtask

  always @(posedge clk) begin
    frame_word_t e;
    frame_word_t got;
    if (!rst_n) begin
      expected_words.delete();
      phase        = HUNT_A;
      remain       = '0;
      wr_ptr       = '0;
      frame_len    = '0;
      frame_chan   = '0;
      csum         = '0;
      capacity     = 8'hFF;
      mismatch_cnt <= 0;
    end else begin
      if (cfg_we) capacity = cfg_wdata;
      if (in_tvalid && in_tready) parse_rx_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        got.chan = out_tdata[7:0];
        got.word = out_tdata[39:8];
        got.idx  = out_tdata[43:40];
        got.last = out_tlast;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual ch=%h word=%h idx=%0d last=%b",
                   $time, got.chan, got.word, got.idx, got.last);
          mismatch_cnt <= mismatch_cnt + 1;
        end else begin
          e = expected_words.pop_front();
          if (got !== e) begin
            $display({"%0t: word mismatch: expected ch=%h word=%h idx=%0d last=%b,",
                      " actual ch=%h word=%h idx=%0d last=%b"},
                     $time, e.chan, e.word, e.idx, e.last,
                     got.chan, got.word, got.idx, got.last);
            mismatch_cnt <= mismatch_cnt + 1;
          end
        end
      end
    end
    words_pending <= expected_words.size();
  end

endmodule

### tb/tb_sync_frame_word_parser.sv
module tb_sync_frame_word_parser;
  import sfwp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 100;

  typedef logic [7:0] byte_q_t[$];

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_TDATA-1:0] out_tdata;
  logic                 out_tlast;
  logic                 cfg_we;
  logic [CAP_W-1:0]     cfg_wdata;
  int                   mismatch_cnt;
  int                   words_pending;

  bit in_idle_on;
  bit out_idle_on;
  int hold_len;
  int bytes_sent;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sync_frame_word_parser u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  sfwp_word_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatch_cnt  (mismatch_cnt),
    .words_pending (words_pending)
  );

  task automatic send_byte(input logic [7:0] b);
    if (in_idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  // sends the bytes, then their 8-bit sum (corrupted on request)
  task automatic send_block(input byte_q_t q, input bit good_sum);
    logic [7:0] sum;
    sum = '0;
    foreach (q[k]) sum = sum + q[k];
    if (!good_sum) sum = sum ^ 8'($urandom_range(1, 255));
    foreach (q[k]) send_byte(q[k]);
    send_byte(sum);
  endtask

  task automatic send_frame(input int len, input bit good_sum);
    byte_q_t q;
    q = {SYNC_BYTE, SYNC_BYTE, 8'($urandom), 8'(len)};
    repeat (len) q.push_back(8'($urandom));
    send_block(q, good_sum);
  endtask

  task automatic run_random(input int budget);
    int start;
    int pick;
    int len;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 16) : $urandom_range(17, 49);
      if (pick < 65) begin
        send_frame(len, 1'b1);
      end else if (pick < 75) begin
        send_frame(len, 1'b0);
      end else if (pick < 83) begin
        repeat ($urandom_range(1, 3))
          send_byte(($urandom_range(0, 2) == 0) ? SYNC_BYTE : 8'($urandom));
      end else if (pick < 88) begin
        send_byte(SYNC_BYTE);
        send_byte(8'($urandom));
      end else if (pick < 93) begin
        send_byte(SYNC_BYTE);
        send_byte(SYNC_BYTE);
        send_byte(8'($urandom));
        send_byte(8'($urandom_range(LENGTH_LIMIT, 255)));
      end else begin
        send_byte(SYNC_BYTE);
        send_byte(SYNC_BYTE);
        send_byte(8'($urandom));
        send_byte(8'h00);
        send_byte(8'($urandom));
      end
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : rx_side
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        out_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    byte_q_t q;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    hold_len    = 0;
    bytes_sent  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // broken header, oversize length, zero length followed by a sync byte
    send_byte(SYNC_BYTE);
    send_byte(8'h55);
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(SYNC_BYTE);
    q = {SYNC_BYTE, SYNC_BYTE, 8'hFF, 8'h04, 8'hFF, 8'h00, 8'h00, 8'hFF};
    send_block(q, 1'b1);
    // partial word only
    q = {SYNC_BYTE, SYNC_BYTE, 8'h00, 8'h03, 8'h01, 8'h02, 8'h03};
    send_block(q, 1'b1);

    // receiver holds off while frames keep coming
    hold_len = 300;
    send_frame(16, 1'b1);
    run_random(20);
    drain();

    write_capacity(8'd3);
    run_random(10);
    drain();

    write_capacity(8'd0);
    run_random(5);
    drain();

    write_capacity(8'd13);
    send_frame(48, 1'b1);
    run_random(5);
    drain();

    write_capacity(8'd1);
    run_random(5);
    drain();

    write_capacity(8'hFF);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    send_frame(49, 1'b1);
    run_random(10);
    drain();

    if (mismatch_cnt == 0 && words_pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

### files.f
hw/rtl/sfwp_pkg.sv
hw/rtl/sfwp_ram.sv
hw/rtl/sync_frame_word_parser.sv
tb/sfwp_word_checker.sv
tb/tb_sync_frame_word_parser.sv
